[design/gdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, constants and calendar functions for the date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

    // Operation codes carried by a command beat.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NEXT    = 2'd1,
        OP_PREV    = 2'd2,
        OP_COMPARE = 2'd3
    } t_op;

    // Comparison order, stored date versus argument date.
    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } t_order;

    // One calendar date.
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_date;

    // One command as held in the input register.
    typedef struct packed {
        t_op   op;
        t_date arg;
    } t_cmd;

    localparam logic [11:0] YEAR_BEFORE_FIRST = 12'd1582;
    localparam logic [11:0] YEAR_AFTER_LAST   = 12'd2400;
    localparam logic [3:0]  MONTHS_PER_YEAR   = 4'd12;
    localparam logic [3:0]  MONTH_FEB         = 4'd2;
    localparam logic [3:0]  MONTH_APR         = 4'd4;
    localparam logic [3:0]  MONTH_JUN         = 4'd6;
    localparam logic [3:0]  MONTH_SEP         = 4'd9;
    localparam logic [3:0]  MONTH_NOV         = 4'd11;

    localparam t_date RESET_DATE = '{day: 5'd1, month: 4'd1, year: 12'd2000};

    // Reciprocal of 25 scaled by 2^15; exact quotient for any 12-bit year.
    localparam logic [11:0] RECIP_25 = 12'd1311;

    // Gregorian leap-year test. Divisibility by 100 and 400 is split into
    // divisibility by 4 or 16 and by 25; the remainder by 25 comes from a
    // reciprocal multiply and one subtract.
    function automatic logic is_leap(input logic [11:0] year);
        logic [23:0] prod;
        logic [7:0]  quot;
        logic [11:0] rem;
        logic        div25;
        prod  = year * RECIP_25;
        quot  = prod[22:15];
        rem   = year - {4'd0, quot} * 12'd25;
        div25 = (rem == 12'd0);
        return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
    endfunction

    // Days in a month; months outside 1..12 count as 31 days.
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic       leap);
        logic [4:0] len;
        case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[design/gdc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_cmd_if / gdc_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface gdc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  arg_day;
    logic [3:0]  arg_month;
    logic [11:0] arg_year;

    modport source (output valid, output operation, output arg_day,
                    output arg_month, output arg_year, input ready);
    modport sink   (input valid, input operation, input arg_day,
                    input arg_month, input arg_year, output ready);
endinterface

interface gdc_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic        date_valid;
    logic [1:0]  compare_order;

    modport source (output valid, output out_day, output out_month,
                    output out_year, output date_valid, output compare_order,
                    input ready);
    modport sink   (input valid, input out_day, input out_month,
                    input out_year, input date_valid, input compare_order,
                    output ready);
endinterface

[design/gregorian_date_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_counter
// Calendar date register with load, next day, previous day and compare.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per beat: operation, arg_day, arg_month and
//   arg_year. o_res returns exactly one result beat per command, in order:
//   the stored date after the operation, its validity and, for compare,
//   the order of the stored date against the argument.
//   A command is held in the input register from the edge that accepts
//   it, and moves on into the date/result register once that register
//   is free or drains.
//   Throughput is one command per cycle while o_res.ready stays high; the
//   date update is combinational, and its longest path is the leap-year
//   test feeding the month-length compare.
//   A synchronous active-low reset empties both registers and sets the
//   stored date to 1 January 2000.
//   When the receiver holds o_res.ready low, the result beat holds, the
//   input register still takes one more command, and i_cmd.ready then drops
//   until the result is taken.
// ----------------------------------------------------------------------------
module gregorian_date_counter (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gdc_cmd_if.sink  i_cmd,
    gdc_res_if.source o_res
);

    logic            in_valid;
    gdc_pkg::t_cmd   in_cmd;
    logic            advance;
    gdc_pkg::t_date  n_date;
    gdc_pkg::t_order n_order;
    logic            cur_valid;

    logic            r_out_valid;
    gdc_pkg::t_date  r_date;
    gdc_pkg::t_order r_order;

    // A command moves on when the result register is free or drains.
    assign advance = in_valid && (!r_out_valid || o_res.ready);

    // Input register.
    gdc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_cmd   (in_cmd)
    );

    // Date update and comparison.
    gdc_step u_step (
        .i_cur       (r_date),
        .i_cmd       (in_cmd),
        .o_next      (n_date),
        .o_order     (n_order),
        .o_cur_valid (cur_valid)
    );

    // Stored date, which is also the result date, and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_date      <= gdc_pkg::RESET_DATE;
            r_order     <= gdc_pkg::ORD_LESS;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_date      <= n_date;
            r_order     <= n_order;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result beat.
    assign o_res.valid         = r_out_valid;
    assign o_res.out_day       = r_date.day;
    assign o_res.out_month     = r_date.month;
    assign o_res.out_year      = r_date.year;
    assign o_res.date_valid    = cur_valid;
    assign o_res.compare_order = r_order;

endmodule

[design/gdc_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_in_stage
// Input register for command beats; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module gdc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gdc_cmd_if.sink       i_cmd,
    input  logic          i_take,
    output logic          o_valid,
    output gdc_pkg::t_cmd o_cmd
);

    logic          r_valid;
    gdc_pkg::t_cmd r_cmd;

    // Accept a new beat when empty or when the held one moves on.
    assign i_cmd.ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd.op        <= gdc_pkg::t_op'(i_cmd.operation);
            r_cmd.arg.day   <= i_cmd.arg_day;
            r_cmd.arg.month <= i_cmd.arg_month;
            r_cmd.arg.year  <= i_cmd.arg_year;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

[design/gdc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_step
// Next-date, comparison and validity logic for one command.
// ----------------------------------------------------------------------------
module gdc_step (
    input  gdc_pkg::t_date  i_cur,
    input  gdc_pkg::t_cmd   i_cmd,
    output gdc_pkg::t_date  o_next,
    output gdc_pkg::t_order o_order,
    output logic            o_cur_valid
);

    logic       cur_leap;
    logic [4:0] cur_len;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [3:0] month_dec;

    assign cur_leap  = gdc_pkg::is_leap(i_cur.year);
    assign cur_len   = gdc_pkg::month_length(i_cur.month, cur_leap);
    assign day_inc   = {1'b0, i_cur.day} + 6'd1;
    assign month_inc = {1'b0, i_cur.month} + 5'd1;
    assign month_dec = i_cur.month - 4'd1;

    // Next stored date.
    always_comb begin
        o_next = i_cur;
        unique case (i_cmd.op)
            gdc_pkg::OP_LOAD: begin
                o_next = i_cmd.arg;
            end
            gdc_pkg::OP_NEXT: begin
                if (day_inc > {1'b0, cur_len}) begin
                    o_next.day = 5'd1;
                    if (month_inc > {1'b0, gdc_pkg::MONTHS_PER_YEAR}) begin
                        o_next.month = 4'd1;
                        o_next.year  = i_cur.year + 12'd1;
                    end else begin
                        o_next.month = month_inc[3:0];
                    end
                end else begin
                    o_next.day = day_inc[4:0];
                end
            end
            gdc_pkg::OP_PREV: begin
                if (i_cur.day <= 5'd1) begin
                    // December always has 31 days, so no leap test of the
                    // new year is needed when the year steps back.
                    if (i_cur.month <= 4'd1) begin
                        o_next.month = gdc_pkg::MONTHS_PER_YEAR;
                        o_next.year  = i_cur.year - 12'd1;
                        o_next.day   = 5'd31;
                    end else begin
                        o_next.month = month_dec;
                        o_next.day   = gdc_pkg::month_length(month_dec, cur_leap);
                    end
                end else begin
                    o_next.day = i_cur.day - 5'd1;
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

    // Order: years first, then months, then days. Zero outside compare.
    always_comb begin
        o_order = gdc_pkg::ORD_LESS;
        if (i_cmd.op == gdc_pkg::OP_COMPARE) begin
            if (i_cur.year != i_cmd.arg.year) begin
                o_order = (i_cur.year > i_cmd.arg.year) ? gdc_pkg::ORD_GREATER
                                                        : gdc_pkg::ORD_LESS;
            end else if (i_cur.month != i_cmd.arg.month) begin
                o_order = (i_cur.month > i_cmd.arg.month) ? gdc_pkg::ORD_GREATER
                                                          : gdc_pkg::ORD_LESS;
            end else if (i_cur.day != i_cmd.arg.day) begin
                o_order = (i_cur.day > i_cmd.arg.day) ? gdc_pkg::ORD_GREATER
                                                      : gdc_pkg::ORD_LESS;
            end else begin
                o_order = gdc_pkg::ORD_EQUAL;
            end
        end
    end

    // Validity of the stored date.
    assign o_cur_valid = (i_cur.year > gdc_pkg::YEAR_BEFORE_FIRST) &&
                         (i_cur.year < gdc_pkg::YEAR_AFTER_LAST) &&
                         (i_cur.month >= 4'd1) &&
                         (i_cur.month <= gdc_pkg::MONTHS_PER_YEAR) &&
                         (i_cur.day >= 5'd1) &&
                         (i_cur.day <= cur_len);

endmodule

[tb/date_counter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_counter_checker
// Watches the command and result channels of the date counter. It keeps its
// own copy of the stored date, works out the result of every accepted
// command beat, and compares each result beat field by field against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module date_counter_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    gdc_cmd_if   i_cmd,
    gdc_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    // One predicted result beat.
    typedef struct packed {
        gdc_pkg::t_date  date;
        logic            ok;
        gdc_pkg::t_order order;
    } t_date_result;

    gdc_pkg::t_date cur_date;
    t_date_result   expected_dates[$];
    t_date_result   want;
    t_date_result   got;
    int             errors;

    // Gregorian leap year: divisible by 4 and not by 100, or divisible by 400.
    function automatic bit leap_year(input logic [11:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in a month; months outside 1..12 count as 31 days.
    function automatic logic [4:0] days_in_month(input logic [3:0] m,
                                                 input logic [11:0] y);
        case (m)
            gdc_pkg::MONTH_APR, gdc_pkg::MONTH_JUN,
            gdc_pkg::MONTH_SEP, gdc_pkg::MONTH_NOV: return 5'd30;
            gdc_pkg::MONTH_FEB: return leap_year(y) ? 5'd29 : 5'd28;
            default:   return 5'd31;
        endcase
    endfunction

    // Valid when the year lies in the Gregorian window, the month is 1..12 and the day fits.
    function automatic logic date_ok(input gdc_pkg::t_date d);
        if (d.year <= gdc_pkg::YEAR_BEFORE_FIRST || d.year >= gdc_pkg::YEAR_AFTER_LAST)
            return 1'b0;
        if (d.month < 4'd1 || d.month > gdc_pkg::MONTHS_PER_YEAR) return 1'b0;
        if (d.day < 5'd1 || d.day > days_in_month(d.month, d.year)) return 1'b0;
        return 1'b1;
    endfunction

    // Three-way unsigned order.
    function automatic gdc_pkg::t_order order_of(input int a, input int b);
        if (a < b) return gdc_pkg::ORD_LESS;
        if (a > b) return gdc_pkg::ORD_GREATER;
        return gdc_pkg::ORD_EQUAL;
    endfunction

    // Applies one command to the stored date and returns the result beat.
    function automatic t_date_result step_date(input gdc_pkg::t_op op,
                                               input gdc_pkg::t_date arg);
        t_date_result r;
        int           next_day;
        r.order  = gdc_pkg::ORD_LESS;
        next_day = int'(cur_date.day) + 1;
        case (op)
            gdc_pkg::OP_LOAD: cur_date = arg;
            gdc_pkg::OP_NEXT: begin
                if (next_day > int'(days_in_month(cur_date.month, cur_date.year))) begin
                    cur_date.day = 5'd1;
                    // Month 12 and the bad months 13..15 all roll into January.
                    if (cur_date.month >= gdc_pkg::MONTHS_PER_YEAR) begin
                        cur_date.month = 4'd1;
                        cur_date.year  = cur_date.year + 12'd1;
                    end else begin
                        cur_date.month = cur_date.month + 4'd1;
                    end
                end else begin
                    cur_date.day = 5'(next_day);
                end
            end
            gdc_pkg::OP_PREV: begin
                if (cur_date.day <= 5'd1) begin
                    if (cur_date.month <= 4'd1) begin
                        cur_date.month = gdc_pkg::MONTHS_PER_YEAR;
                        cur_date.year  = cur_date.year - 12'd1;
                    end else begin
                        cur_date.month = cur_date.month - 4'd1;
                    end
                    cur_date.day = days_in_month(cur_date.month, cur_date.year);
                end else begin
                    cur_date.day = cur_date.day - 5'd1;
                end
            end
            default: begin
                // Years decide first, then months, then days.
                r.order = order_of(int'(cur_date.year), int'(arg.year));
                if (r.order == gdc_pkg::ORD_EQUAL)
                    r.order = order_of(int'(cur_date.month), int'(arg.month));
                if (r.order == gdc_pkg::ORD_EQUAL)
                    r.order = order_of(int'(cur_date.day), int'(arg.day));
            end
        endcase
        r.date = cur_date;
        r.ok   = date_ok(cur_date);
        return r;
    endfunction

    initial begin
        errors       = 0;
        cur_date     = gdc_pkg::RESET_DATE;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Result beats are checked before the command beat of the same edge is
    // predicted; the block cannot answer a command in the cycle it takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_date = gdc_pkg::RESET_DATE;
            expected_dates.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.date  = '{day: i_res.out_day, month: i_res.out_month,
                              year: i_res.out_year};
                got.ok    = i_res.date_valid;
                got.order = gdc_pkg::t_order'(i_res.compare_order);
                if (expected_dates.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("%0t: result beat with no command outstanding: %0d/%0d/%0d",
                                 $time, got.date.day, got.date.month, got.date.year);
                end else begin
                    want = expected_dates.pop_front();
                    if (got.date.day !== want.date.day || got.date.month !== want.date.month ||
                        got.date.year !== want.date.year || got.ok !== want.ok ||
                        got.order !== want.order) begin
                        errors = errors + 1;
                        // Fields: day/month/year, valid flag, compare order.
                        if (errors <= 10)
                            $display("%0t: expected %0d/%0d/%0d %0b %0d, got %0d/%0d/%0d %0b %0d",
                                     $time,
                                     want.date.day, want.date.month, want.date.year,
                                     want.ok, want.order, got.date.day, got.date.month,
                                     got.date.year, got.ok, got.order);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_dates.push_back(step_date(gdc_pkg::t_op'(i_cmd.operation),
                    '{day: i_cmd.arg_day, month: i_cmd.arg_month, year: i_cmd.arg_year}));
        end
        o_fail_count <= errors;
        o_pending    <= expected_dates.size();
    end

endmodule

[tb/tb_gregorian_date_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_counter
// Drives command beats into the date counter and gives the verdict.
// A directed run covers the calendar corners (month and year ends, leap
// rules, year wrap, bad months and days, all compare orders); then random
// loads, runs of next/previous day and compares follow, with random idle
// bursts on the command side and stall bursts on the result side.
// ----------------------------------------------------------------------------
module tb_gregorian_date_counter;

    localparam int TOTAL_ITEMS = 1850;
    localparam int QUIET_TAIL  = 150;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    int             fail_count;
    int             pending;
    bit             quiet;
    int             gap_odds;
    int             stall_odds;
    int             sent;
    int             next_phase;
    int             pick;
    int             run_len;
    gdc_pkg::t_date last_load;
    gdc_pkg::t_date probe;

    gdc_cmd_if cmd_ch();
    gdc_res_if res_ch();

    gregorian_date_counter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    date_counter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: ready stays high for a while, then may stall for a burst.
    initial begin
        forever begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 99) < stall_odds) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    end

    // Sends one command beat, after an optional idle burst, and returns at
    // the edge that accepts it.
    task automatic send_cmd(input gdc_pkg::t_op op, input logic [4:0] d,
                            input logic [3:0] m, input logic [11:0] y);
        if (!quiet && $urandom_range(0, 99) < gap_odds) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.arg_day   <= d;
        cmd_ch.arg_month <= m;
        cmd_ch.arg_year  <= y;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sent = sent + 1;
        if (op == gdc_pkg::OP_LOAD) last_load = '{day: d, month: m, year: y};
    endtask

    // Loads a date that is mostly well formed, with years near the edges.
    task automatic load_plausible();
        logic [11:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        case ($urandom_range(0, 5))
            0: y = 12'($urandom_range(1583, 2399));
            1: y = 12'($urandom_range(0, 1) ? $urandom_range(1582, 1583)
                                            : $urandom_range(2399, 2400));
            2: y = 12'(100 * $urandom_range(15, 40));
            3: y = 12'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                            : $urandom_range(4092, 4095));
            4: y = 12'(4 * $urandom_range(395, 600));
            default: y = 12'($urandom_range(0, 4095));
        endcase
        m = 4'($urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 12));
        d = 5'($urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(0, 3));
        send_cmd(gdc_pkg::OP_LOAD, d, m, y);
    endtask

    // Compares against the last loaded date, as it is or nudged by one in one field.
    task automatic compare_near();
        probe = last_load;
        case ($urandom_range(0, 3))
            0: ;
            1: probe.day   = probe.day + ($urandom_range(0, 1) ? 5'd1 : 5'h1f);
            2: probe.month = probe.month + ($urandom_range(0, 1) ? 4'd1 : 4'hf);
            default: probe.year = probe.year + ($urandom_range(0, 1) ? 12'd1 : 12'hfff);
        endcase
        send_cmd(gdc_pkg::OP_COMPARE, probe.day, probe.month, probe.year);
    endtask

    initial begin
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= gdc_pkg::OP_LOAD;
        cmd_ch.arg_day   <= '0;
        cmd_ch.arg_month <= '0;
        cmd_ch.arg_year  <= '0;
        i_rst_n          <= 1'b0;
        quiet      = 1'b0;
        gap_odds   = 20;
        stall_odds = 20;
        sent       = 0;
        next_phase = 0;
        last_load  = gdc_pkg::RESET_DATE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners.
        send_cmd(gdc_pkg::OP_COMPARE, 5'd1, 4'd1, 12'd2000);    // reset date, equal
        send_cmd(gdc_pkg::OP_LOAD, 5'd31, 4'd12, 12'd2399);     // last valid day
        send_cmd(gdc_pkg::OP_NEXT, 5'd0, 4'd0, 12'd0);          // into 2400, invalid
        send_cmd(gdc_pkg::OP_PREV, 5'd31, 4'd15, 12'd4095);
        send_cmd(gdc_pkg::OP_LOAD, 5'd28, 4'd2, 12'd2000);      // leap by 400
        send_cmd(gdc_pkg::OP_NEXT, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_NEXT, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_PREV, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_LOAD, 5'd28, 4'd2, 12'd1900);      // century, not leap
        send_cmd(gdc_pkg::OP_NEXT, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_LOAD, 5'd1, 4'd1, 12'd0);          // year wraps downward
        send_cmd(gdc_pkg::OP_PREV, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_NEXT, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_LOAD, 5'd31, 4'd15, 12'd4095);     // all ones, bad month
        send_cmd(gdc_pkg::OP_NEXT, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_LOAD, 5'd0, 4'd13, 12'd1583);      // day zero, bad month
        send_cmd(gdc_pkg::OP_PREV, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_LOAD, 5'd0, 4'd0, 12'd2004);       // month zero
        send_cmd(gdc_pkg::OP_NEXT, 5'd0, 4'd0, 12'd0);
        send_cmd(gdc_pkg::OP_COMPARE, 5'd31, 4'd15, 12'd4095);  // less
        send_cmd(gdc_pkg::OP_COMPARE, 5'd0, 4'd0, 12'd0);       // greater
        send_cmd(gdc_pkg::OP_COMPARE, 5'd1, 4'd0, 12'd2004);    // equal
        send_cmd(gdc_pkg::OP_COMPARE, 5'd2, 4'd0, 12'd2004);    // less on the day
        send_cmd(gdc_pkg::OP_LOAD, 5'd1, 4'd3, 12'd2004);
        send_cmd(gdc_pkg::OP_PREV, 5'd0, 4'd0, 12'd0);          // back into a leap Feb

        // Random mix; idle and stall rates change every hundred beats.
        while (sent < TOTAL_ITEMS) begin
            if (sent >= next_phase) begin
                next_phase = next_phase + 100;
                gap_odds   = 20 * $urandom_range(0, 3);
                stall_odds = 20 * $urandom_range(0, 3);
            end
            quiet = (sent >= TOTAL_ITEMS - QUIET_TAIL);
            pick  = $urandom_range(0, 99);
            if (pick < 10) begin
                send_cmd(gdc_pkg::OP_LOAD, 5'($urandom_range(0, 31)),
                         4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            end else if (pick < 35) begin
                load_plausible();
                if ($urandom_range(0, 2) == 0) compare_near();
            end else if (pick < 85) begin
                // A run of day steps walks across month and year ends.
                run_len = $urandom_range(1, 40);
                if (run_len > TOTAL_ITEMS - sent) run_len = TOTAL_ITEMS - sent;
                repeat (run_len)
                    send_cmd(pick < 65 ? gdc_pkg::OP_NEXT : gdc_pkg::OP_PREV,
                             5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                             12'($urandom_range(0, 4095)));
            end else begin
                compare_near();
            end
        end
        cmd_ch.valid <= 1'b0;

        // Drain the outstanding results, then allow for stray beats.
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
